// File: design/sus_pkg.sv
// Package: shared types and constants of the sorted unique set unit.
package sus_pkg;

    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_LOOKUP  = 2'd2,
        FUNC_READOUT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FOUND     = 3'd4,
        STS_EMPTY     = 3'd5,
        STS_FULL      = 3'd6,
        STS_ENTRY     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        IDX_HOLD  = 2'd0,
        IDX_INC   = 2'd1,
        IDX_DEC   = 2'd2,
        IDX_COUNT = 2'd3
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_DOWN = 2'd1,
        RD_UP   = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    typedef enum logic [1:0] {
        VAL_KEY   = 2'd0,
        VAL_ZERO  = 2'd1,
        VAL_RDATA = 2'd2
    } val_sel_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] key_value;
    } req_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic               last_of_run;
        logic [5:0]         entry_count;
    } rsp_word_t;

    typedef struct packed {
        logic     load_req;
        idx_op_t  idx_op;
        logic     pos_load;
        logic     hit_load;
        logic     mem_rd;
        rd_sel_t  rd_sel;
        logic     mem_wr;
        logic     wr_key;
        cnt_op_t  cnt_op;
        logic     out_load;
        status_t  out_status;
        val_sel_t out_val;
        logic     out_last;
    } sus_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       out_free;
        logic       idx_at_count;
        logic       idx_at_pos;
        logic       idx_last;
        logic       ro_last;
        logic       less;
        logic       equal;
        logic       hit;
        logic       count_zero;
        logic       count_full;
    } sus_sts_t;

endpackage

// File: design/sorted_unique_set_unit.sv
// Top level: sorted unique set unit, controller plus datapath.
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | req_word_t  (func, key_value)
//  m_      | out       | m_valid / m_ready  | rsp_word_t  (status, item_value,
//          |           |                    |              last_of_run, entry_count)
//
// One request at a time. The scan reads the store one entry after another
// (registered read, then compare) and stops at the insert or remove point;
// insert and remove then shift only the entries past it, each entry moved by
// a read and then a write. Readout reads each entry, then emits it as a word.
// Reset (aresetn low, synchronous) empties the set. A stalled m_ready holds
// the controller at its next result; the result register lets a new request
// be accepted while a word waits.
module sorted_unique_set_unit #(
    parameter int CAPACITY = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sus_pkg::req_word_t s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output sus_pkg::rsp_word_t m_word
);
    import sus_pkg::*;

    sus_cmd_t cmd;
    sus_sts_t sts;

    sus_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_word.func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sus_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// File: design/sus_datapath.sv
// Datapath: entry store, index and count registers, compare and result register.
module sus_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sus_pkg::req_word_t s_word,
    input  sus_pkg::sus_cmd_t  cmd,
    output sus_pkg::sus_sts_t  sts,
    output logic              m_valid,
    input  logic              m_ready,
    output sus_pkg::rsp_word_t m_word
);
    import sus_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [31:0] mem [CAPACITY];

    logic [1:0]         func_reg;
    logic signed [31:0] key_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               hit_reg;
    logic signed [31:0] rdata_reg;
    logic               m_valid_reg;
    rsp_word_t          m_word_reg;

    logic [CNT_W-1:0]   idx_up, idx_dn, rd_idx;
    logic signed [31:0] out_val;

    assign idx_up = idx_reg + CNT_W'(1);
    assign idx_dn = idx_reg - CNT_W'(1);

    always_comb begin
        case (cmd.rd_sel)
            RD_DOWN: rd_idx = idx_dn;
            RD_UP:   rd_idx = idx_up;
            default: rd_idx = idx_reg;
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_comb begin
        if (cmd.load_req) begin
            idx_next = '0;
        end else begin
            case (cmd.idx_op)
                IDX_INC:   idx_next = idx_up;
                IDX_DEC:   idx_next = idx_dn;
                IDX_COUNT: idx_next = cnt_reg;
                default:   idx_next = idx_reg;
            endcase
        end
    end

    always_comb begin
        case (cmd.out_val)
            VAL_ZERO:  out_val = '0;
            VAL_RDATA: out_val = rdata_reg;
            default:   out_val = key_reg;
        endcase
    end

    // entry store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[idx_reg[ADDR_W-1:0]] <= cmd.wr_key ? key_reg : rdata_reg;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            func_reg <= s_word.func;
            key_reg  <= s_word.key_value;
        end
        if (cmd.pos_load) begin
            pos_reg <= idx_reg;
        end
        if (cmd.out_load) begin
            m_word_reg.status      <= cmd.out_status;
            m_word_reg.item_value  <= out_val;
            m_word_reg.last_of_run <= cmd.out_last;
            m_word_reg.entry_count <= 6'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (cmd.load_req) begin
                hit_reg <= 1'b0;
            end else if (cmd.hit_load) begin
                hit_reg <= (rdata_reg == key_reg);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.func         = func_reg;
    assign sts.out_free     = !m_valid_reg || m_ready;
    assign sts.idx_at_count = (idx_reg == cnt_reg);
    assign sts.idx_at_pos   = (idx_reg == pos_reg);
    assign sts.idx_last     = (idx_up == cnt_reg);
    assign sts.ro_last      = (idx_up == cnt_reg) || (7'(idx_reg) == 7'(MAX_RESULTS - 1));
    assign sts.less         = (rdata_reg < key_reg);
    assign sts.equal        = (rdata_reg == key_reg);
    assign sts.hit          = hit_reg;
    assign sts.count_zero   = (cnt_reg == '0);
    assign sts.count_full   = (cnt_reg >= CNT_W'(CAPACITY));

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// File: design/sus_controller.sv
// Controller: state machine sequencing scan, shift and readout over the datapath.
module sus_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_func,
    output logic             s_ready,
    input  sus_pkg::sus_sts_t sts,
    output sus_pkg::sus_cmd_t cmd
);
    import sus_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_SCAN_RD  = 10'b0000000010,
        ST_SCAN_CMP = 10'b0000000100,
        ST_DECIDE   = 10'b0000001000,
        ST_UP_RD    = 10'b0000010000,
        ST_UP_WR    = 10'b0000100000,
        ST_DN_RD    = 10'b0001000000,
        ST_DN_WR    = 10'b0010000000,
        ST_RO_RD    = 10'b0100000000,
        ST_RO_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.idx_op     = IDX_HOLD;
        cmd.rd_sel     = RD_IDX;
        cmd.cnt_op     = CNT_HOLD;
        cmd.out_status = STS_INSERTED;
        cmd.out_val    = VAL_KEY;
        cmd.out_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = (s_func == FUNC_READOUT) ? ST_RO_RD : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (sts.idx_at_count) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (sts.less) begin
                    cmd.idx_op = IDX_INC;
                    state_next = ST_SCAN_RD;
                end else begin
                    cmd.hit_load = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.func == FUNC_INSERT) begin
                    if (sts.hit || sts.count_full) begin
                        cmd.out_status = sts.hit ? STS_DUPLICATE : STS_FULL;
                        if (sts.out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        cmd.pos_load = 1'b1;
                        cmd.idx_op   = IDX_COUNT;
                        state_next   = ST_UP_RD;
                    end
                end else if (sts.func == FUNC_REMOVE && sts.hit) begin
                    state_next = ST_DN_RD;
                end else begin
                    if (sts.func == FUNC_REMOVE) begin
                        cmd.out_status = sts.count_zero ? STS_EMPTY : STS_NOT_FOUND;
                    end else begin
                        cmd.out_status = sts.hit ? STS_FOUND : STS_NOT_FOUND;
                    end
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_UP_RD: begin
                if (sts.idx_at_pos) begin
                    if (sts.out_free) begin
                        cmd.mem_wr     = 1'b1;
                        cmd.wr_key     = 1'b1;
                        cmd.cnt_op     = CNT_INC;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STS_INSERTED;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_DOWN;
                    state_next = ST_UP_WR;
                end
            end
            ST_UP_WR: begin
                cmd.mem_wr = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = ST_UP_RD;
            end
            ST_DN_RD: begin
                if (sts.idx_last) begin
                    if (sts.out_free) begin
                        cmd.cnt_op     = CNT_DEC;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STS_REMOVED;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_UP;
                    state_next = ST_DN_WR;
                end
            end
            ST_DN_WR: begin
                cmd.mem_wr = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = ST_DN_RD;
            end
            ST_RO_RD: begin
                if (sts.count_zero) begin
                    cmd.out_status = STS_EMPTY;
                    cmd.out_val    = VAL_ZERO;
                    if (sts.out_free) begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_RO_EMIT;
                end
            end
            ST_RO_EMIT: begin
                cmd.out_status = STS_ENTRY;
                cmd.out_val    = VAL_RDATA;
                cmd.out_last   = sts.ro_last;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.ro_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = ST_RO_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_rd_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.mem_rd && cmd.mem_wr))
        else $error("store read and write in the same cycle");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cnt_op == CNT_INC) |-> !sts.count_full)
        else $error("count incremented when full");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("controller idle after accepting a request");
`endif

endmodule

// File: tb/sorted_unique_set_unit_tb.sv
// Testbench: sorted unique set unit, directed table then random words, checked against table words or a set model.
`timescale 1ns / 100ps

module sorted_unique_set_unit_tb;
    import sus_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int DIR_ROWS    = 23;
    localparam int TAIL_CYCLES = 4 * CAPACITY + 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        func_t      func;
        logic [31:0] key;
        logic       typed;
        rsp_word_t  want;
    } dir_row_t;

    typedef struct packed {
        logic      typed;
        rsp_word_t want;
    } req_note_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    req_word_t s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rsp_word_t m_word;

    logic signed [31:0] set_store [CAPACITY];
    int                 set_count = 0;
    rsp_word_t          pred_words [$];
    rsp_word_t          due_rsp [$];
    req_note_t          req_notes [$];
    req_note_t          cur_note;
    rsp_word_t          want_w;
    dir_row_t           dir_tab [DIR_ROWS];
    int                 errors = 0;
    int                 stall_cycles = 0;
    bit                 quiet = 1'b0;

    sorted_unique_set_unit #(.CAPACITY(CAPACITY)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 8);
    end

    // set model: applies one request, leaves its words in pred_words
    task automatic set_apply(input req_word_t rq);
        int                 pos;
        int                 n;
        logic               hit;
        logic signed [31:0] key;
        pred_words.delete();
        key = rq.key_value;
        if (rq.func == FUNC_READOUT) begin
            n = (set_count > MAX_RESULTS) ? MAX_RESULTS : set_count;
            if (set_count == 0) begin
                pred_words.push_back('{STS_EMPTY, 32'sd0, 1'b1, 6'd0});
            end else begin
                for (int i = 0; i < n; i++)
                    pred_words.push_back('{STS_ENTRY, set_store[i], (i == n - 1),
                                           6'(set_count)});
            end
            return;
        end
        pos = 0;
        while (pos < set_count && set_store[pos] < key) pos++;
        hit = (pos < set_count) && (set_store[pos] == key);
        case (rq.func)
            FUNC_INSERT: begin
                if (hit) begin
                    pred_words.push_back('{STS_DUPLICATE, key, 1'b1, 6'(set_count)});
                end else if (set_count >= CAPACITY) begin
                    pred_words.push_back('{STS_FULL, key, 1'b1, 6'(set_count)});
                end else begin
                    for (int i = set_count; i > pos; i--) set_store[i] = set_store[i - 1];
                    set_store[pos] = key;
                    set_count++;
                    pred_words.push_back('{STS_INSERTED, key, 1'b1, 6'(set_count)});
                end
            end
            FUNC_REMOVE: begin
                if (set_count == 0) begin
                    pred_words.push_back('{STS_EMPTY, key, 1'b1, 6'(set_count)});
                end else if (!hit) begin
                    pred_words.push_back('{STS_NOT_FOUND, key, 1'b1, 6'(set_count)});
                end else begin
                    for (int i = pos; i + 1 < set_count; i++) set_store[i] = set_store[i + 1];
                    set_count--;
                    pred_words.push_back('{STS_REMOVED, key, 1'b1, 6'(set_count)});
                end
            end
            default: begin
                pred_words.push_back('{hit ? STS_FOUND : STS_NOT_FOUND, key, 1'b1,
                                       6'(set_count)});
            end
        endcase
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 32'($urandom_range(16)) - 32'd8;
        else if (sel == 5)
            return 32'h7fff_ffff - 32'($urandom_range(2));
        else if (sel == 6)
            return 32'h8000_0000 + 32'($urandom_range(2));
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] stored_or_random();
        if (set_count > 0 && $urandom_range(9) < 6)
            return set_store[$urandom_range(set_count - 1)];
        return pick_key();
    endfunction

    task automatic send_req(input func_t f, input logic [31:0] k, input logic typed,
                            input rsp_word_t want);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 8) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req_notes.push_back('{typed, want});
        s_valid <= 1'b1;
        s_word  <= '{func: f, key_value: k};
        do @(posedge aclk); while (!s_ready);
    endtask

    // request and result words, checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                cur_note = req_notes.pop_front();
                set_apply(s_word);
                if (cur_note.typed)
                    due_rsp.push_back(cur_note.want);
                else
                    foreach (pred_words[i]) due_rsp.push_back(pred_words[i]);
            end
            if (m_valid && m_ready) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: unexpected word, actual %p", $time, m_word);
                    errors++;
                end else begin
                    want_w = due_rsp.pop_front();
                    if (m_word.status !== want_w.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_w.status, m_word.status);
                        errors++;
                    end
                    if (m_word.item_value !== want_w.item_value) begin
                        $display("%0t: item_value expected %0d actual %0d",
                                 $time, want_w.item_value, m_word.item_value);
                        errors++;
                    end
                    if (m_word.last_of_run !== want_w.last_of_run) begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want_w.last_of_run, m_word.last_of_run);
                        errors++;
                    end
                    if (m_word.entry_count !== want_w.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want_w.entry_count, m_word.entry_count);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] first_key;
        logic [31:0] k;
        dir_tab = '{
            '{FUNC_READOUT, 32'h0000_0000, 1'b1, '{STS_EMPTY, 32'h0000_0000, 1'b1, 6'd0}},
            '{FUNC_REMOVE,  32'h0000_0005, 1'b1, '{STS_EMPTY, 32'h0000_0005, 1'b1, 6'd0}},
            '{FUNC_LOOKUP,  32'h0000_0005, 1'b1,
              '{STS_NOT_FOUND, 32'h0000_0005, 1'b1, 6'd0}},
            '{FUNC_INSERT,  32'h7fff_ffff, 1'b1,
              '{STS_INSERTED, 32'h7fff_ffff, 1'b1, 6'd1}},
            '{FUNC_INSERT,  32'h8000_0000, 1'b1,
              '{STS_INSERTED, 32'h8000_0000, 1'b1, 6'd2}},
            '{FUNC_INSERT,  32'h0000_0000, 1'b1,
              '{STS_INSERTED, 32'h0000_0000, 1'b1, 6'd3}},
            '{FUNC_INSERT,  32'h0000_0000, 1'b1,
              '{STS_DUPLICATE, 32'h0000_0000, 1'b1, 6'd3}},
            '{FUNC_LOOKUP,  32'h8000_0000, 1'b1, '{STS_FOUND, 32'h8000_0000, 1'b1, 6'd3}},
            '{FUNC_LOOKUP,  32'h7fff_ffff, 1'b1, '{STS_FOUND, 32'h7fff_ffff, 1'b1, 6'd3}},
            '{FUNC_LOOKUP,  32'h0000_0001, 1'b1,
              '{STS_NOT_FOUND, 32'h0000_0001, 1'b1, 6'd3}},
            '{FUNC_REMOVE,  32'h0000_0001, 1'b1,
              '{STS_NOT_FOUND, 32'h0000_0001, 1'b1, 6'd3}},
            '{FUNC_READOUT, 32'h0000_0000, 1'b0, '0},
            '{FUNC_REMOVE,  32'h8000_0000, 1'b1,
              '{STS_REMOVED, 32'h8000_0000, 1'b1, 6'd2}},
            '{FUNC_INSERT,  32'hffff_ffff, 1'b0, '0},
            '{FUNC_INSERT,  32'h0000_0001, 1'b0, '0},
            '{FUNC_INSERT,  32'h8000_0001, 1'b0, '0},
            '{FUNC_READOUT, 32'h0000_0000, 1'b0, '0},
            '{FUNC_REMOVE,  32'h7fff_ffff, 1'b0, '0},
            '{FUNC_REMOVE,  32'h0000_0000, 1'b0, '0},
            '{FUNC_LOOKUP,  32'h0000_0000, 1'b0, '0},
            '{FUNC_READOUT, 32'hffff_ffff, 1'b0, '0},
            '{FUNC_INSERT,  32'h7fff_ffff, 1'b0, '0},
            '{FUNC_LOOKUP,  32'h7fff_fffe, 1'b0, '0}
        };
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i].func, dir_tab[i].key, dir_tab[i].typed, dir_tab[i].want);

        // mixed traffic over a small key range, so hits are common
        repeat (12) begin
            case ($urandom_range(3))
                0: send_req(FUNC_INSERT, pick_key(), 1'b0, '0);
                1: send_req(FUNC_REMOVE, stored_or_random(), 1'b0, '0);
                2: send_req(FUNC_LOOKUP, stored_or_random(), 1'b0, '0);
                default: send_req(FUNC_READOUT, $urandom, 1'b0, '0);
            endcase
        end

        // fill to capacity with no idling on either side
        quiet = 1'b1;
        first_key = $urandom;
        send_req(FUNC_INSERT, first_key, 1'b0, '0);
        repeat (CAPACITY + 2) send_req(FUNC_INSERT, $urandom, 1'b0, '0);
        send_req(FUNC_INSERT, first_key, 1'b0, '0);
        send_req(FUNC_READOUT, 32'h0, 1'b0, '0);
        send_req(FUNC_LOOKUP, first_key, 1'b0, '0);
        quiet = 1'b0;

        // drain
        repeat (36) begin
            k = (set_count > 0 && $urandom_range(9) < 8) ?
                set_store[$urandom_range(set_count - 1)] : pick_key();
            send_req(FUNC_REMOVE, k, 1'b0, '0);
        end
        while (set_count > 0) send_req(FUNC_REMOVE, set_store[0], 1'b0, '0);
        send_req(FUNC_REMOVE, pick_key(), 1'b0, '0);
        send_req(FUNC_LOOKUP, pick_key(), 1'b0, '0);
        send_req(FUNC_READOUT, $urandom, 1'b0, '0);
        s_valid <= 1'b0;

        while (due_rsp.size() != 0 || req_notes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && due_rsp.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/sus_pkg.sv
design/sus_datapath.sv
design/sus_controller.sv
design/sorted_unique_set_unit.sv
tb/sorted_unique_set_unit_tb.sv
